### rtl/uvll_pkg.sv
// ----------------------------------------------------------------------------
// uvll_pkg
// Shared constants and the arctangent table for the lat/lon converter.
// ----------------------------------------------------------------------------
package uvll_pkg;

    localparam int ANGLE_W      = 24;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [ANGLE_W-1:0] DEG90 = 24'sd2949120;
    localparam logic signed [14:0] LAT_MAX = 15'sd11520;
    localparam logic signed [15:0] LON_MAX = 16'sd23040;
    localparam logic [15:0] POLE_THRESHOLD_RESET = 16'd268;
    localparam logic [1:0] REG_POLE_THRESHOLD = 2'd0;

    // arctangent of 2^-i in 1/32768 degree
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input int i);
        logic signed [ANGLE_W-1:0] t;
        begin
            case (i)
                0:  t = 24'sd1474560;
                1:  t = 24'sd870484;
                2:  t = 24'sd459940;
                3:  t = 24'sd233473;
                4:  t = 24'sd117189;
                5:  t = 24'sd58652;
                6:  t = 24'sd29333;
                7:  t = 24'sd14667;
                8:  t = 24'sd7334;
                9:  t = 24'sd3667;
                10: t = 24'sd1833;
                11: t = 24'sd917;
                12: t = 24'sd458;
                13: t = 24'sd229;
                14: t = 24'sd115;
                15: t = 24'sd57;
                16: t = 24'sd29;
                17: t = 24'sd14;
                18: t = 24'sd7;
                19: t = 24'sd4;
                20: t = 24'sd2;
                21: t = 24'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

### rtl/uvll_sqrt.sv
// ----------------------------------------------------------------------------
// uvll_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module uvll_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [28:0]      radicand,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [14:0]      root,
    output logic [TAG_W-1:0] out_tag
);
    import uvll_pkg::*;

    localparam int STEPS = 15;
    localparam int PER   = 2;
    localparam int NST   = (STEPS + PER - 1) / PER;

    logic [NST:0]       vld_reg;
    logic [29:0]        rem_reg  [NST+1];
    logic [14:0]        res_reg  [NST+1];
    logic [TAG_W-1:0]   tag_reg  [NST+1];

    always_comb
    begin
        rem_reg[0] = {1'b0, radicand};
        res_reg[0] = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    // digit-by-digit: step k tests result bit (14-k)
    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [29:0] rem_next;
        logic [14:0] res_next;
        always_comb
        begin
            logic [29:0] trial;
            trial    = '0;
            rem_next = rem_reg[s];
            res_next = res_reg[s];
            for (int j = 0; j < PER; j++) begin
                if (s * PER + j < STEPS) begin
                    trial = ({15'd0, res_next} << ((14 - (s * PER + j)) + 1))
                          | (30'd1 << (2 * (14 - (s * PER + j))));
                    if (rem_next >= trial) begin
                        rem_next = rem_next - trial;
                        res_next = res_next | (15'd1 << (14 - (s * PER + j)));
                    end
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (adv)
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (adv) begin
                rem_reg[s+1] <= rem_next;
                res_reg[s+1] <= res_next;
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NST];
    assign root      = res_reg[NST];
    assign out_tag   = tag_reg[NST];

endmodule

### rtl/uvll_cordic.sv
// ----------------------------------------------------------------------------
// uvll_cordic
// Unrolled CORDIC vectoring pipeline: atan2(y, x), one rotation per stage.
// ----------------------------------------------------------------------------
module uvll_cordic #(
    parameter int STAGES = 16,
    parameter int CW     = 16,
    parameter int TAG_W  = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [CW-1:0]                xin,
    input  logic signed [CW-1:0]                yin,
    input  logic [TAG_W-1:0]                    in_tag,
    output logic                                out_valid,
    output logic signed [uvll_pkg::ANGLE_W-1:0] angle,
    output logic [TAG_W-1:0]                    out_tag
);
    import uvll_pkg::*;

    // operands are widened by 3 bits for growth through pre-rotation and gain
    localparam int DW = CW + 3;

    logic [STAGES:0]              vld_reg;
    logic signed [DW-1:0]         xv_reg [STAGES+1];
    logic signed [DW-1:0]         yv_reg [STAGES+1];
    logic signed [ANGLE_W-1:0]    a_reg  [STAGES+1];
    logic [TAG_W-1:0]             tag_reg[STAGES+1];

    logic signed [DW-1:0] xe, ye;
    assign xe = DW'(xin);
    assign ye = DW'(yin);

    // pre-rotation into the right half-plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv) begin
            tag_reg[0] <= in_tag;
            if (xe < 0 && ye >= 0) begin
                xv_reg[0] <= ye;
                yv_reg[0] <= -xe;
                a_reg[0]  <= DEG90;
            end
            else if (xe < 0) begin
                xv_reg[0] <= -ye;
                yv_reg[0] <= xe;
                a_reg[0]  <= -DEG90;
            end
            else begin
                xv_reg[0] <= xe;
                yv_reg[0] <= ye;
                a_reg[0]  <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [DW-1:0] dx, dy;
        assign dx = yv_reg[i] >>> i;
        assign dy = xv_reg[i] >>> i;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv) begin
                tag_reg[i+1] <= tag_reg[i];
                if (yv_reg[i] >= 0) begin
                    xv_reg[i+1] <= xv_reg[i] + dx;
                    yv_reg[i+1] <= yv_reg[i] - dy;
                    a_reg[i+1]  <= a_reg[i] + atan_entry(i);
                end
                else begin
                    xv_reg[i+1] <= xv_reg[i] - dx;
                    yv_reg[i+1] <= yv_reg[i] + dy;
                    a_reg[i+1]  <= a_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign angle     = a_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

### rtl/unit_vector_to_lat_lon.sv
// ----------------------------------------------------------------------------
// unit_vector_to_lat_lon
// Unit vector (Q2.14) to latitude / longitude in 1/128 degree.
// ----------------------------------------------------------------------------
// Pipeline: 1 input stage + 8 square-root stages + CORDIC_STAGES+1 CORDIC
// stages + 1 output stage.
// Throughput: one vector per cycle; a stall freezes the whole pipeline.
// Reset: clears all valid bits; pole_threshold returns to 268.
module unit_vector_to_lat_lon #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic signed [15:0] z_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] latitude,
    output logic signed [15:0] longitude,
    output logic               at_pole
);
    import uvll_pkg::*;

    localparam int CW = COORD_WIDTH;

    // one extra bit so that -x of the most negative input still fits
    typedef struct packed {
        logic              pole;
        logic signed [CW:0] z;
        logic signed [CW:0] nx;
    } side_t;

    logic [15:0] thr_reg;
    logic        adv;

    // output register advances when empty or being taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign pready   = 1'b1;
    assign prdata   = {16'd0, thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= POLE_THRESHOLD_RESET;
        else if (psel && penable && pwrite && paddr == REG_POLE_THRESHOLD)
            thr_reg <= pwdata[15:0];
    end

    function automatic logic signed [CW:0] scale_in(input logic signed [16:0] v);
        logic signed [CW+16:0] t;
        begin
            t = (CW+17)'(v);
            if (CW >= 16)
                return (CW+1)'(t <<< (CW - 16));
            else
                return (CW+1)'(t >>> (16 - CW));
        end
    endfunction

    // stage 0: squares, clamp, pole test
    logic               v0_reg;
    logic [28:0]        rad0_reg;
    logic signed [15:0] yc0_reg;
    side_t              s0_reg;

    logic signed [15:0] yc;
    logic signed [31:0] xw, yw, zw;
    logic [31:0]        mag_sq;
    logic [31:0]        rad;
    always_comb
    begin
        if (y_in > 16'sd16384)
            yc = 16'sd16384;
        else if (y_in < -16'sd16384)
            yc = -16'sd16384;
        else
            yc = y_in;
        xw     = 32'(x_in);
        yw     = 32'(yc);
        zw     = 32'(z_in);
        mag_sq = 32'(xw * xw) + 32'(zw * zw);
        rad    = 32'h1000_0000 - 32'(yw * yw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv) begin
            rad0_reg   <= rad[28:0];
            yc0_reg    <= yc;
            s0_reg.pole <= mag_sq < {16'd0, thr_reg};
            s0_reg.z    <= scale_in(17'(z_in));
            s0_reg.nx   <= scale_in(-17'(x_in));
        end
    end

    localparam int TAG_A = 16 + $bits(side_t);
    logic               v1;
    logic [14:0]        c1;
    logic [TAG_A-1:0]   t1;
    uvll_sqrt #(.TAG_W(TAG_A)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(v0_reg), .radicand(rad0_reg), .in_tag({yc0_reg, s0_reg}),
        .out_valid(v1), .root(c1), .out_tag(t1)
    );

    side_t              s1;
    logic signed [15:0] yc1;
    assign s1  = t1[$bits(side_t)-1:0];
    assign yc1 = t1[TAG_A-1 -: 16];

    logic                      vlat, vlon;
    logic signed [ANGLE_W-1:0] alat, alon;
    logic                      pole2;
    logic                      unused_tag;

    uvll_cordic #(.STAGES(CORDIC_STAGES), .CW(CW + 1), .TAG_W(1)) u_lat (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v1),
        .xin(scale_in({2'b00, c1})), .yin(scale_in(17'(yc1))), .in_tag(s1.pole),
        .out_valid(vlat), .angle(alat), .out_tag(pole2)
    );
    uvll_cordic #(.STAGES(CORDIC_STAGES), .CW(CW + 1), .TAG_W(1)) u_lon (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v1),
        .xin(s1.nx), .yin(s1.z), .in_tag(1'b0),
        .out_valid(vlon), .angle(alon), .out_tag(unused_tag)
    );

    function automatic logic signed [ANGLE_W-9:0] rnd(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W:0] t;
        begin
            t = (ANGLE_W+1)'(a) + (ANGLE_W+1)'(128);
            return (ANGLE_W-8)'(t >>> 8);
        end
    endfunction

    logic signed [ANGLE_W-9:0] rlat, rlon;
    logic signed [14:0] lat_next;
    logic signed [15:0] lon_next;
    always_comb
    begin
        rlat = rnd(alat);
        rlon = rnd(alon);
        if (rlat > (ANGLE_W-8)'(LAT_MAX))
            lat_next = LAT_MAX;
        else if (rlat < -(ANGLE_W-8)'(LAT_MAX))
            lat_next = -LAT_MAX;
        else
            lat_next = 15'(rlat);
        if (rlon > (ANGLE_W-8)'(LON_MAX))
            lon_next = LON_MAX;
        else if (rlon < -(ANGLE_W-8)'(LON_MAX))
            lon_next = -LON_MAX;
        else
            lon_next = 16'(rlon);
    end

    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vlat;
    end
    always_ff @(posedge clk)
    begin
        if (adv) begin
            latitude  <= pole2 ? LAT_MAX : lat_next;
            longitude <= pole2 ? 16'sd0 : lon_next;
            at_pole   <= pole2 ^ (unused_tag & 1'b0);
        end
    end
    assign out_valid = ov_reg;

    a_lanes_match: assert property (@(posedge clk) disable iff (!rst_n) vlat == vlon)
        else $error("lat and lon lanes out of step");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(latitude) && $stable(longitude))
        else $error("stalled result changed");
    a_pole_lon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_pole |-> longitude == 16'sd0 && latitude == LAT_MAX)
        else $error("pole result wrong");

endmodule

### tb/tb_unit_vector_to_lat_lon.sv
// ----------------------------------------------------------------------------
// tb_unit_vector_to_lat_lon
// Streams Q2.14 vectors through the converter under random source and sink
// gaps and compares each latitude/longitude result against a bit-exact
// CORDIC prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_unit_vector_to_lat_lon;
    import uvll_pkg::*;

    localparam int STAGES    = 16;
    localparam int LIMIT     = 2000000;
    localparam int DRAIN     = 40;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic signed [14:0] lat;
        logic signed [15:0] lon;
        logic               pole;
    } angles_t;

    class angle_board;
        angles_t     pending_q[$];
        logic [15:0] threshold;
        int          errors;

        function new();
            threshold = POLE_THRESHOLD_RESET;
            errors    = 0;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // vectoring CORDIC, angle in 1/32768 degree
        static function longint vec_angle(longint yv, longint xv);
            longint a, t, dx, dy;
            a = 0;
            if (xv < 0)
            begin
                if (yv >= 0)
                begin
                    t = xv; xv = yv; yv = -t; a = DEG90;
                end
                else
                begin
                    t = xv; xv = -yv; yv = t; a = -DEG90;
                end
            end
            for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (yv >= 0)
                begin
                    xv += dx; yv -= dy; a += atan_entry(i);
                end
                else
                begin
                    xv -= dx; yv += dy; a -= atan_entry(i);
                end
            end
            return a;
        endfunction

        static function longint round_sat(longint a, longint lim);
            longint r;
            r = (a + 128) >>> 8;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function void note_input(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
            angles_t e;
            longint  xl, yl, zl, yc, c;
            longint unsigned mag_sq;
            xl = x; yl = y; zl = z;
            mag_sq = xl * xl + zl * zl;
            if (mag_sq < threshold)
            begin
                e.lat  = LAT_MAX;
                e.lon  = '0;
                e.pole = 1'b1;
            end
            else
            begin
                yc = yl;
                if (yc > 16384) yc = 16384;
                if (yc < -16384) yc = -16384;
                c = int_sqrt((64'd1 << 28) - yc * yc);
                e.lat  = 15'(round_sat(vec_angle(yc, c), LAT_MAX));
                e.lon  = 16'(round_sat(vec_angle(zl, -xl), LON_MAX));
                e.pole = 1'b0;
            end
            pending_q.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic signed [14:0] lat, logic signed [15:0] lon,
                          logic pole);
            angles_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result lat=%0d lon=%0d", lat, lon));
                return;
            end
            e = pending_q.pop_front();
            if (lat !== e.lat)
                report($sformatf("latitude %0d, want %0d", lat, e.lat));
            if (lon !== e.lon)
                report($sformatf("longitude %0d, want %0d", lon, e.lon));
            if (pole !== e.pole)
                report($sformatf("at_pole %0b, want %0b", pole, e.pole));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] x_in, y_in, z_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [14:0] latitude;
    logic signed [15:0] longitude;
    logic               at_pole;

    angle_board board;
    bit         quiet;
    bit         hold_req;
    int         cycles;

    unit_vector_to_lat_lon DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .latitude(latitude), .longitude(longitude), .at_pole(at_pole)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(latitude, longitude, at_pole);

    function automatic int gap();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        int g;
        g = gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_in <= x;
        y_in <= y;
        z_in <= z;
        do @(posedge clk); while (in_stall);
        board.note_input(x, y, z);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 2'(REG_POLE_THRESHOLD * 4);
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.threshold = v;
    endtask

    // mostly unit vectors, some near the poles, some raw noise
    task automatic send_random();
        real la, lo;
        int  k;
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            la = ($urandom_range(0, 100000) / 100000.0 - 0.5) * 3.14159265;
            lo = ($urandom_range(0, 100000) / 100000.0 - 0.5) * 6.28318531;
            send_vector(16'($rtoi(-16384.0 * $cos(la) * $cos(lo))),
                        16'($rtoi(16384.0 * $sin(la))),
                        16'($rtoi(16384.0 * $cos(la) * $sin(lo))));
        end
        else if (k < 8)
            send_vector(16'($signed($urandom_range(0, 40)) - 20),
                        $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384,
                        16'($signed($urandom_range(0, 40)) - 20));
        else
            send_vector(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [15:0] limits[5];
        board    = new();
        cycles   = 0;
        quiet    = 0;
        hold_req = 0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        x_in     <= '0;
        y_in     <= '0;
        z_in     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, axes, both poles, clamped y
        send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
        send_vector(16'sd32767, 16'sd32767, 16'sd32767);
        send_vector(0, 16'sd16384, 0);
        send_vector(0, -16'sd16384, 0);
        send_vector(0, 0, 0);
        send_vector(-16'sd16384, 0, 0);
        send_vector(16'sd16384, 0, 0);
        send_vector(0, 0, 16'sd16384);
        send_vector(0, 0, -16'sd16384);
        send_vector(16'sd16384, 0, -16'sd1);
        send_vector(16'sd16384, 0, 16'sd1);
        send_vector(16'sd11, 16'sd20000, 16'sd11);
        send_vector(16'sd12, -16'sd20000, 0);
        send_vector(16'sd9459, 16'sd9459, 16'sd9459);
        send_vector(16'sd32767, -16'sd32768, -16'sd1);
        drain();

        limits = '{16'd268, 16'd0, 16'd65535, 16'($urandom), 16'd1};
        foreach (limits[p])
        begin
            write_threshold(limits[p]);
            if (p == 1)
            begin
                // throat: back up the pipeline while sending back to back
                quiet    = 1;
                hold_req = 1;
            end
            if (p == 3)
                send_vector(0, 0, 0);
            for (int n = 0; n < 350; n++)
            begin
                if (n == 150)
                    quiet = 0;
                if (n == 200)
                    drain();
                if (n == 300)
                    quiet = 1;
                send_random();
            end
            quiet = 0;
            drain();
        end

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int w;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            w = gap();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

endmodule
